@@ rtl/core/ffa_pkg.sv @@
// Shared constants, op codes and types of the first-fit extent allocator.
package ffa_pkg;

    localparam int MAX_EXTENTS = 64;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int PAGE_SHIFT  = 12;
    localparam int PAGE_BYTES  = 1 << PAGE_SHIFT;
    localparam int HDR_BYTES   = 8;
    localparam int MIN_SPLIT   = 16;
    localparam int BUDGET_W    = 21;
    localparam logic [BUDGET_W-1:0] BUDGET_RST = 21'h100000;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_PAGE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE        = 5'd0;
    localparam logic [OP_W-1:0] OP_LATCH       = 5'd1;
    localparam logic [OP_W-1:0] OP_LARGE       = 5'd2;
    localparam logic [OP_W-1:0] OP_FS_INIT     = 5'd3;
    localparam logic [OP_W-1:0] OP_FS_RD       = 5'd4;
    localparam logic [OP_W-1:0] OP_FS_NEXT     = 5'd5;
    localparam logic [OP_W-1:0] OP_FOUND       = 5'd6;
    localparam logic [OP_W-1:0] OP_DR_RD       = 5'd7;
    localparam logic [OP_W-1:0] OP_DR_WR       = 5'd8;
    localparam logic [OP_W-1:0] OP_DR_END      = 5'd9;
    localparam logic [OP_W-1:0] OP_SPLIT_PUT   = 5'd10;
    localparam logic [OP_W-1:0] OP_GRANT_WHOLE = 5'd11;
    localparam logic [OP_W-1:0] OP_NOPAGE      = 5'd12;
    localparam logic [OP_W-1:0] OP_PAGE_PUT    = 5'd13;
    localparam logic [OP_W-1:0] OP_PAGE_WHOLE  = 5'd14;
    localparam logic [OP_W-1:0] OP_FREE_PUT    = 5'd15;
    localparam logic [OP_W-1:0] OP_PS_RD       = 5'd16;
    localparam logic [OP_W-1:0] OP_PS_PREV     = 5'd17;
    localparam logic [OP_W-1:0] OP_MERGE_BOTH  = 5'd18;
    localparam logic [OP_W-1:0] OP_MERGE_PREV  = 5'd19;
    localparam logic [OP_W-1:0] OP_MERGE_NEXT  = 5'd20;
    localparam logic [OP_W-1:0] OP_SU_INIT     = 5'd21;
    localparam logic [OP_W-1:0] OP_SU_RD       = 5'd22;
    localparam logic [OP_W-1:0] OP_SU_WR       = 5'd23;
    localparam logic [OP_W-1:0] OP_SU_END      = 5'd24;
    localparam logic [OP_W-1:0] OP_FULL_STATUS = 5'd25;
    localparam logic [OP_W-1:0] OP_PAGE_COMMIT = 5'd26;

    typedef struct packed {
        logic [31:0] start_addr;
        logic [31:0] len;
    } t_extent;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic is_alloc;
        logic is_small;
        logic free_small_nz;
        logic idx_eq_cnt;
        logic k_eq_idx;
        logic fit;
        logic start_le;
        logic drop_last;
        logic split_ok;
        logic page_ok;
        logic page_split;
        logic pa;
        logic na;
        logic full;
    } t_dp_stat;

endpackage

@@ rtl/core/ffa_ctrl.sv @@
// Sequencing state machine of the first-fit extent allocator.
module ffa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ffa_pkg::t_dp_stat i_stat,
    output ffa_pkg::t_dp_cmd  o_cmd,
    output logic             o_busy,
    output logic             o_valid
);
    import ffa_pkg::*;

    localparam logic [4:0] S_IDLE       = 5'd0;
    localparam logic [4:0] S_DECODE     = 5'd1;
    localparam logic [4:0] S_FS_RD      = 5'd2;
    localparam logic [4:0] S_FS_CK      = 5'd3;
    localparam logic [4:0] S_DR_RD      = 5'd4;
    localparam logic [4:0] S_DR_WR      = 5'd5;
    localparam logic [4:0] S_FOUND_POST = 5'd6;
    localparam logic [4:0] S_NOFIT      = 5'd7;
    localparam logic [4:0] S_PS_RD      = 5'd8;
    localparam logic [4:0] S_PS_CK      = 5'd9;
    localparam logic [4:0] S_PUT_EVAL   = 5'd10;
    localparam logic [4:0] S_SU_RD      = 5'd11;
    localparam logic [4:0] S_SU_WR      = 5'd12;
    localparam logic [4:0] S_PUT_OK     = 5'd13;
    localparam logic [4:0] S_PUT_FAIL   = 5'd14;
    localparam logic [4:0] S_DONE       = 5'd15;

    localparam logic [1:0] ORG_FREE  = 2'd0;
    localparam logic [1:0] ORG_SPLIT = 2'd1;
    localparam logic [1:0] ORG_PAGE  = 2'd2;

    logic [4:0] r_state, n_state;
    logic [1:0] r_origin, n_origin;
    logic       r_after, n_after;   // 1: drop belongs to a merge, 0: to a fit

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_origin <= ORG_FREE;
            r_after  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_origin <= n_origin;
            r_after  <= n_after;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_origin = r_origin;
        n_after  = r_after;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_alloc) begin
                    if (i_stat.is_small) begin
                        o_cmd.op = OP_FS_INIT;
                        n_state  = S_FS_RD;
                    end else begin
                        o_cmd.op = OP_LARGE;
                        n_state  = S_DONE;
                    end
                end else if (i_stat.free_small_nz) begin
                    o_cmd.op = OP_FREE_PUT;
                    n_origin = ORG_FREE;
                    n_state  = S_PS_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FS_RD: begin
                if (i_stat.idx_eq_cnt) begin
                    n_state = S_NOFIT;
                end else begin
                    o_cmd.op = OP_FS_RD;
                    n_state  = S_FS_CK;
                end
            end
            S_FS_CK: begin
                if (i_stat.fit) begin
                    o_cmd.op = OP_FOUND;
                    n_after  = 1'b0;
                    n_state  = S_DR_RD;
                end else begin
                    o_cmd.op = OP_FS_NEXT;
                    n_state  = S_FS_RD;
                end
            end
            S_DR_RD: begin
                if (i_stat.drop_last) begin
                    o_cmd.op = OP_DR_END;
                    n_state  = r_after ? S_PUT_OK : S_FOUND_POST;
                end else begin
                    o_cmd.op = OP_DR_RD;
                    n_state  = S_DR_WR;
                end
            end
            S_DR_WR: begin
                o_cmd.op = OP_DR_WR;
                n_state  = S_DR_RD;
            end
            S_FOUND_POST: begin
                if (i_stat.split_ok) begin
                    o_cmd.op = OP_SPLIT_PUT;
                    n_origin = ORG_SPLIT;
                    n_state  = S_PS_RD;
                end else begin
                    o_cmd.op = OP_GRANT_WHOLE;
                    n_state  = S_DONE;
                end
            end
            S_NOFIT: begin
                if (!i_stat.page_ok) begin
                    o_cmd.op = OP_NOPAGE;
                    n_state  = S_DONE;
                end else if (i_stat.page_split) begin
                    o_cmd.op = OP_PAGE_PUT;
                    n_origin = ORG_PAGE;
                    n_state  = S_PS_RD;
                end else begin
                    o_cmd.op = OP_PAGE_WHOLE;
                    n_state  = S_DONE;
                end
            end
            S_PS_RD: begin
                if (i_stat.idx_eq_cnt) begin
                    n_state = S_PUT_EVAL;
                end else begin
                    o_cmd.op = OP_PS_RD;
                    n_state  = S_PS_CK;
                end
            end
            S_PS_CK: begin
                if (i_stat.start_le) begin
                    o_cmd.op = OP_PS_PREV;
                    n_state  = S_PS_RD;
                end else begin
                    n_state = S_PUT_EVAL;
                end
            end
            S_PUT_EVAL: begin
                if (i_stat.pa && i_stat.na) begin
                    o_cmd.op = OP_MERGE_BOTH;
                    n_after  = 1'b1;
                    n_state  = S_DR_RD;
                end else if (i_stat.pa) begin
                    o_cmd.op = OP_MERGE_PREV;
                    n_state  = S_PUT_OK;
                end else if (i_stat.na) begin
                    o_cmd.op = OP_MERGE_NEXT;
                    n_state  = S_PUT_OK;
                end else if (i_stat.full) begin
                    n_state = S_PUT_FAIL;
                end else begin
                    o_cmd.op = OP_SU_INIT;
                    n_state  = S_SU_RD;
                end
            end
            S_SU_RD: begin
                if (i_stat.k_eq_idx) begin
                    o_cmd.op = OP_SU_END;
                    n_state  = S_PUT_OK;
                end else begin
                    o_cmd.op = OP_SU_RD;
                    n_state  = S_SU_WR;
                end
            end
            S_SU_WR: begin
                o_cmd.op = OP_SU_WR;
                n_state  = S_SU_RD;
            end
            S_PUT_OK: begin
                if (r_origin == ORG_PAGE) begin
                    o_cmd.op = OP_PAGE_COMMIT;
                end
                n_state = S_DONE;
            end
            S_PUT_FAIL: begin
                o_cmd.op = OP_FULL_STATUS;
                n_state  = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

@@ rtl/core/ffa_dp.sv @@
// Datapath of the first-fit extent allocator: extent table, counters, result.
module ffa_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ffa_pkg::t_dp_cmd                i_cmd,
    input  logic                            i_cmd_bit,
    input  logic [22:0]                     i_req_size,
    input  logic [31:0]                     i_free_addr,
    input  logic [31:0]                     i_block_size,
    input  logic [ffa_pkg::BUDGET_W-1:0]    i_budget,
    output ffa_pkg::t_dp_stat               o_stat,
    output logic [1:0]                      o_status,
    output logic [31:0]                     o_grant_addr,
    output logic [31:0]                     o_grant_size,
    output logic [ffa_pkg::BUDGET_W-1:0]    o_pages_used,
    output logic [ffa_pkg::CNT_W-1:0]       o_free_entries
);
    import ffa_pkg::*;

    t_extent mem [MAX_EXTENTS];

    logic                r_is_alloc;
    logic [23:0]         r_size;
    logic [31:0]         r_faddr;
    logic [31:0]         r_bsize;
    logic [CNT_W-1:0]    r_cnt;
    logic [BUDGET_W-1:0] r_np;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_k;
    logic [31:0]         r_s;
    logic [31:0]         r_len;
    logic [31:0]         r_put_s;
    logic [31:0]         r_put_len;
    t_extent             r_prev;
    t_extent             r_rdata;
    logic [1:0]          r_status;
    logic [31:0]         r_gaddr;
    logic [31:0]         r_gsize;

    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    t_extent          wr_data;

    logic [32:0] ps, ns, prev_end, put_end;
    logic [33:0] both;
    logic        pa_raw, na_raw;
    logic [24:0] large_round;
    logic [12:0] large_n;
    logic [21:0] large_end;
    logic [31:0] np_addr;
    logic [31:0] split_rem;

    // Merge candidates around the insertion point.
    assign ps       = {1'b0, r_prev.len} + {1'b0, r_put_len};
    assign ns       = {1'b0, r_put_len} + {1'b0, r_rdata.len};
    assign both     = {1'b0, ps} + {2'b00, r_rdata.len};
    assign prev_end = {1'b0, r_prev.start_addr} + {1'b0, r_prev.len};
    assign put_end  = {1'b0, r_put_s} + {1'b0, r_put_len};
    assign pa_raw   = (r_idx != '0) && (prev_end == {1'b0, r_put_s}) && !ps[32];
    assign na_raw   = (r_idx < r_cnt) && (put_end == {1'b0, r_rdata.start_addr})
                      && !ns[32];

    assign large_round = {1'b0, r_size} + 25'(PAGE_BYTES - 1);
    assign large_n     = large_round[24:PAGE_SHIFT];
    assign large_end   = {1'b0, r_np} + 22'(large_n);
    assign np_addr     = 32'({r_np, {PAGE_SHIFT{1'b0}}});
    assign split_rem   = r_len - 32'(r_size);

    always_comb begin
        o_stat.is_alloc      = r_is_alloc;
        o_stat.is_small      = (r_size < 24'(PAGE_BYTES));
        o_stat.free_small_nz = (r_bsize < 32'(PAGE_BYTES)) && (r_bsize != '0);
        o_stat.idx_eq_cnt    = (r_idx == r_cnt);
        o_stat.k_eq_idx      = (r_k == r_idx);
        o_stat.fit           = (r_rdata.len >= 32'(r_size));
        o_stat.start_le      = (r_rdata.start_addr <= r_put_s);
        o_stat.drop_last     = ((r_idx + 1'b1) >= r_cnt);
        o_stat.split_ok      = (split_rem >= 32'(MIN_SPLIT));
        o_stat.page_ok       = (({1'b0, r_np} + 22'd1) <= {1'b0, i_budget});
        o_stat.page_split    = (r_size <= 24'(PAGE_BYTES - MIN_SPLIT));
        o_stat.pa            = pa_raw;
        o_stat.na            = na_raw && !(pa_raw && (both[33:32] != 2'b00));
        o_stat.full          = (r_cnt == CNT_W'(MAX_EXTENTS));
    end

    // Table port control.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = r_idx[IDX_W-1:0];
        wr_data = r_rdata;
        case (i_cmd.op)
            OP_FS_RD, OP_PS_RD: begin
                rd_en = 1'b1;
            end
            OP_DR_RD: begin
                rd_en   = 1'b1;
                rd_addr = IDX_W'(r_idx + 1'b1);
            end
            OP_SU_RD: begin
                rd_en   = 1'b1;
                rd_addr = IDX_W'(r_k - 1'b1);
            end
            OP_DR_WR: begin
                wr_en = 1'b1;
            end
            OP_SU_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_k[IDX_W-1:0];
            end
            OP_MERGE_BOTH: begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(r_idx - 1'b1);
                wr_data = '{start_addr: r_prev.start_addr, len: both[31:0]};
            end
            OP_MERGE_PREV: begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(r_idx - 1'b1);
                wr_data = '{start_addr: r_prev.start_addr, len: ps[31:0]};
            end
            OP_MERGE_NEXT: begin
                wr_en   = 1'b1;
                wr_data = '{start_addr: r_put_s, len: ns[31:0]};
            end
            OP_SU_END: begin
                wr_en   = 1'b1;
                wr_data = '{start_addr: r_put_s, len: r_put_len};
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Control counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_np  <= '0;
        end else begin
            case (i_cmd.op)
                OP_DR_END:      r_cnt <= r_cnt - 1'b1;
                OP_SU_END:      r_cnt <= r_cnt + 1'b1;
                OP_LARGE: begin
                    if (large_end <= {1'b0, i_budget}) r_np <= large_end[BUDGET_W-1:0];
                end
                OP_PAGE_WHOLE,
                OP_PAGE_COMMIT: r_np <= r_np + 1'b1;
                default:        r_cnt <= r_cnt;
            endcase
        end
    end

    // Working registers and result.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH: begin
                r_is_alloc <= (i_cmd_bit == CMD_ALLOC);
                r_size     <= {1'b0, i_req_size} + 24'(HDR_BYTES);
                r_faddr    <= i_free_addr;
                r_bsize    <= i_block_size;
                r_status   <= ST_OK;
                r_gaddr    <= '0;
                r_gsize    <= '0;
            end
            OP_LARGE: begin
                if (large_end <= {1'b0, i_budget}) begin
                    r_gaddr <= np_addr + 32'(HDR_BYTES);
                    r_gsize <= 32'({large_n, {PAGE_SHIFT{1'b0}}});
                end else begin
                    r_status <= ST_NO_PAGE;
                end
            end
            OP_FS_INIT: r_idx <= '0;
            OP_FS_NEXT: r_idx <= r_idx + 1'b1;
            OP_FOUND: begin
                r_s   <= r_rdata.start_addr;
                r_len <= r_rdata.len;
            end
            OP_DR_WR: r_idx <= r_idx + 1'b1;
            OP_SPLIT_PUT: begin
                r_put_s   <= r_s + 32'(r_size);
                r_put_len <= split_rem;
                r_gaddr   <= r_s + 32'(HDR_BYTES);
                r_gsize   <= 32'(r_size);
                r_idx     <= '0;
            end
            OP_GRANT_WHOLE: begin
                r_gaddr <= r_s + 32'(HDR_BYTES);
                r_gsize <= r_len;
            end
            OP_NOPAGE: r_status <= ST_NO_PAGE;
            OP_PAGE_PUT: begin
                r_put_s   <= np_addr + 32'(r_size);
                r_put_len <= 32'(PAGE_BYTES) - 32'(r_size);
                r_idx     <= '0;
            end
            OP_PAGE_WHOLE: begin
                r_gaddr <= np_addr + 32'(HDR_BYTES);
                r_gsize <= 32'(PAGE_BYTES);
            end
            OP_PAGE_COMMIT: begin
                r_gaddr <= np_addr + 32'(HDR_BYTES);
                r_gsize <= 32'(r_size);
            end
            OP_FREE_PUT: begin
                r_put_s   <= r_faddr - 32'(HDR_BYTES);
                r_put_len <= r_bsize;
                r_idx     <= '0;
            end
            OP_PS_PREV: begin
                r_prev <= r_rdata;
                r_idx  <= r_idx + 1'b1;
            end
            OP_SU_INIT: r_k <= r_cnt;
            OP_SU_WR:   r_k <= r_k - 1'b1;
            OP_FULL_STATUS: r_status <= ST_FULL;
            default: r_k <= r_k;
        endcase
    end

    assign o_status       = r_status;
    assign o_grant_addr   = r_gaddr;
    assign o_grant_size   = r_gsize;
    assign o_pages_used   = r_np;
    assign o_free_entries = r_cnt;

endmodule

@@ rtl/core/first_fit_extent_allocator.sv @@
// Top level of the first-fit extent allocator: config port and core.
//
// Usage: raise start with cmd and its operands while busy is low; the item
// is taken at that edge and busy stays high until the result is shown.
// An allocate (cmd 0) asks for req_size bytes plus an 8-byte header; a
// small block is served first-fit from an address-ordered table of free
// extents (split when 16 or more bytes remain), else from a fresh page. A
// large request takes a run of fresh pages. A free (cmd 1) of a small
// block goes back into the table and merges with its neighbors.
// Each item yields one result on the o_ ports, marked by o_valid high for
// exactly one cycle; the receiver cannot stall, so take it then.
// A large allocate or a large or empty free goes from decode straight to
// its result; other items walk the extent table, where every table access
// is a read followed by a check or a write, and an item may scan the table,
// drop one entry, scan the table again and insert another entry.
// Throughput is one item at a time; the next start is taken the cycle
// after o_valid.
// Reset empties the table and the page counter and sets page_budget to
// 2^20 pages; no clearing pass is needed. page_budget is written over the
// APB port at address 0, by the user only while the block is idle; the block does not enforce it.
module first_fit_extent_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [1:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cmd,
    input  logic [22:0]                  i_req_size,
    input  logic [31:0]                  i_free_addr,
    input  logic [31:0]                  i_block_size,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [31:0]                  o_grant_addr,
    output logic [31:0]                  o_grant_size,
    output logic [ffa_pkg::BUDGET_W-1:0] o_pages_used,
    output logic [ffa_pkg::CNT_W-1:0]    o_free_entries
);
    import ffa_pkg::*;

    logic [BUDGET_W-1:0] r_budget;
    t_dp_cmd             dp_cmd;
    t_dp_stat            dp_stat;
    logic                cfg_wr;

    // Register writes land in the access phase; the port never waits.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= BUDGET_RST;
        end else if (cfg_wr) begin
            r_budget <= pwdata[BUDGET_W-1:0];
        end
    end

    assign prdata = (paddr == 2'd0) ? {{(32 - BUDGET_W){1'b0}}, r_budget} : '0;

    // Controller sequences the table walk; datapath owns table and counters.
    ffa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    ffa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_cmd_bit      (i_cmd),
        .i_req_size     (i_req_size),
        .i_free_addr    (i_free_addr),
        .i_block_size   (i_block_size),
        .i_budget       (r_budget),
        .o_stat         (dp_stat),
        .o_status       (o_status),
        .o_grant_addr   (o_grant_addr),
        .o_grant_size   (o_grant_size),
        .o_pages_used   (o_pages_used),
        .o_free_entries (o_free_entries)
    );

endmodule
